// ----- hw/rtl/fsc_pkg.sv -----
// fsc_pkg: types, constants and lookup tables for the flip-segment clock sequencer.
// Holds the microcode ROM, the stroke and sweep pattern tables and the digit split helper.
// No dependencies.
package fsc_pkg;

  // Field widths
  localparam int unsigned CfgW   = 10;
  localparam int unsigned WaitW  = 12;
  localparam int unsigned ModW   = 2;
  localparam int unsigned SegW   = 3;
  localparam int unsigned DigW   = 4;
  localparam int unsigned NumMod = 4;
  localparam int unsigned NumSeg = 7;
  localparam int unsigned PcW    = 3;
  localparam int unsigned AddrW  = 4;

  // Loop bounds and time limits
  localparam logic [SegW-1:0] LastSeg   = 3'd6;
  localparam logic [ModW-1:0] LastMod   = 2'd3;
  localparam logic [4:0]      HourMax   = 5'd23;
  localparam logic [5:0]      MinuteMax = 6'd59;
  localparam logic [4:0]      FoldAt    = 5'd12;

  // Register reset values
  localparam logic [CfgW-1:0] SegWriteRst = 10'd20;
  localparam logic [CfgW-1:0] BetweenRst  = 10'd60;
  localparam logic [CfgW-1:0] DigitGapRst = 10'd100;

  // Register indexes on the APB port (byte address / 4)
  typedef enum logic [1:0] {
    REG_SEG_WRITE = 2'd0,
    REG_BETWEEN   = 2'd1,
    REG_DIGIT_GAP = 2'd2
  } reg_idx_e;

  // Input actions
  typedef enum logic [1:0] {
    ACT_INIT    = 2'd0,
    ACT_UPDATE  = 2'd1,
    ACT_SWEEP_R = 2'd2,
    ACT_SWEEP_L = 2'd3
  } act_e;

  // Micro-operations
  typedef enum logic [2:0] {
    OP_WAIT,      // idle, dispatch on the accepted beat
    OP_CLEAR_ALL, // every segment of every module off
    OP_COMMIT,    // shown digits take the new digits
    OP_WRITE,     // write changed digits, module 0 up
    OP_UNWRITE,   // clear changed digits, module 3 down
    OP_SWEEP,     // two passes over the lit segments
    OP_FLUSH      // release the held command as the last one
  } op_e;

  typedef struct packed {
    op_e            op;
    logic [PcW-1:0] next;
  } ctrl_t;

  // Program addresses
  localparam logic [PcW-1:0] PcIdle     = 3'd0;
  localparam logic [PcW-1:0] PcClearAll = 3'd1;
  localparam logic [PcW-1:0] PcCommit   = 3'd2;
  localparam logic [PcW-1:0] PcWrite    = 3'd3;
  localparam logic [PcW-1:0] PcUnwrite  = 3'd4;
  localparam logic [PcW-1:0] PcSweep    = 3'd5;
  localparam logic [PcW-1:0] PcFlush    = 3'd6;

  // Microcode ROM
  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t c;
    unique case (pc)
      PcIdle:     c = '{op: OP_WAIT,      next: PcIdle};
      PcClearAll: c = '{op: OP_CLEAR_ALL, next: PcCommit};
      PcCommit:   c = '{op: OP_COMMIT,    next: PcWrite};
      PcWrite:    c = '{op: OP_WRITE,     next: PcFlush};
      PcUnwrite:  c = '{op: OP_UNWRITE,   next: PcCommit};
      PcSweep:    c = '{op: OP_SWEEP,     next: PcFlush};
      PcFlush:    c = '{op: OP_FLUSH,     next: PcIdle};
      default:    c = '{op: OP_WAIT,      next: PcIdle};
    endcase
    return c;
  endfunction

  // Entry point per action
  function automatic logic [PcW-1:0] dispatch(input act_e act);
    logic [PcW-1:0] pc;
    unique case (act)
      ACT_INIT:    pc = PcClearAll;
      ACT_UPDATE:  pc = PcUnwrite;
      ACT_SWEEP_R: pc = PcSweep;
      ACT_SWEEP_L: pc = PcSweep;
      default:     pc = PcIdle;
    endcase
    return pc;
  endfunction

  // Stroke order per digit, first stroke in the low bits
  function automatic logic [SegW-1:0] stroke(input logic [DigW-1:0] dig,
                                             input logic [SegW-1:0] idx);
    logic [3*NumSeg-1:0] row;
    unique case (dig)
      4'd0:    row = {3'd0, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
      4'd1:    row = {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd1};
      4'd2:    row = {3'd0, 3'd0, 3'd3, 3'd4, 3'd6, 3'd1, 3'd0};
      4'd3:    row = {3'd0, 3'd0, 3'd3, 3'd2, 3'd6, 3'd1, 3'd0};
      4'd4:    row = {3'd0, 3'd0, 3'd0, 3'd2, 3'd1, 3'd6, 3'd5};
      4'd5:    row = {3'd0, 3'd0, 3'd3, 3'd2, 3'd6, 3'd5, 3'd0};
      4'd6:    row = {3'd0, 3'd6, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0};
      4'd7:    row = {3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd1, 3'd0};
      4'd8:    row = {3'd2, 3'd3, 3'd4, 3'd1, 3'd6, 3'd5, 3'd0};
      4'd9:    row = {3'd0, 3'd0, 3'd2, 3'd1, 3'd0, 3'd5, 3'd6};
      default: row = '0;
    endcase
    return row[3*idx +: 3];
  endfunction

  // Strokes per digit; no strokes for a code above nine
  function automatic logic [SegW-1:0] stroke_cnt(input logic [DigW-1:0] dig);
    logic [SegW-1:0] n;
    unique case (dig)
      4'd0:    n = 3'd6;
      4'd1:    n = 3'd2;
      4'd2:    n = 3'd5;
      4'd3:    n = 3'd5;
      4'd4:    n = 3'd4;
      4'd5:    n = 3'd5;
      4'd6:    n = 3'd6;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd7;
      4'd9:    n = 3'd5;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Sweep pattern, first segment in the low bits
  localparam logic [3*NumSeg-1:0] PatRight = {3'd2, 3'd1, 3'd3, 3'd6, 3'd0, 3'd4, 3'd5};
  localparam logic [3*NumSeg-1:0] PatLeft  = {3'd5, 3'd4, 3'd0, 3'd6, 3'd3, 3'd1, 3'd2};

  function automatic logic [SegW-1:0] pattern(input logic left, input logic [SegW-1:0] idx);
    logic [3*NumSeg-1:0] row;
    row = left ? PatLeft : PatRight;
    return row[3*idx +: 3];
  endfunction

  // Tens digit of a minute value, at most 59
  function automatic logic [DigW-1:0] minute_tens(input logic [5:0] v);
    logic [DigW-1:0] t;
    priority if (v >= 6'd50) t = 4'd5;
    else if (v >= 6'd40)     t = 4'd4;
    else if (v >= 6'd30)     t = 4'd3;
    else if (v >= 6'd20)     t = 4'd2;
    else if (v >= 6'd10)     t = 4'd1;
    else                     t = 4'd0;
    return t;
  endfunction

endpackage

// ----- hw/rtl/flip_segment_clock_sequencer.sv -----
// flip_segment_clock_sequencer: microcoded coil-pulse sequencer for four flip-segment digits.
// Depends on fsc_pkg for the microcode ROM, stroke tables and types.
//
// Throughput: one microcode step per cycle while the output does not stall; a new input is
// accepted only once the program is back at idle. A sweep steps through 56 slots and the
// flush step.
// Output path: a command is held until the next pulse or the flush step so that the last one
// can be flagged; it then moves from the held register to the output register. Reset clears
// the lit segments and shown digits, returns the registers to 20/60/100 ms and parks the
// sequencer at idle.
module flip_segment_clock_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [1:0] action, [6:2] hour, [12:7] minute, rest zero
  // Command stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [1:0] module_index, [4:2] segment_index,
                                 // [5] segment_flips, [17:6] wait_ms, rest zero
  output logic        m_tuser,   // [0] turn_on
  output logic        m_tlast,   // last_command
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [fsc_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned ModW  = fsc_pkg::ModW;
  localparam int unsigned SegW  = fsc_pkg::SegW;
  localparam int unsigned DigW  = fsc_pkg::DigW;
  localparam int unsigned WaitW = fsc_pkg::WaitW;
  localparam int unsigned CfgW  = fsc_pkg::CfgW;

  // Sequencer control state
  logic [fsc_pkg::PcW-1:0] pc_q, pc_d;
  logic [ModW-1:0]         mod_q, mod_d;
  logic [SegW-1:0]         idx_q, idx_d;
  logic                    pass_q, pass_d;

  // Clock state and item context
  logic [6:0]      seg_q    [fsc_pkg::NumMod];
  logic [6:0]      before_q [fsc_pkg::NumMod];
  logic [DigW-1:0] shown_q  [fsc_pkg::NumMod];
  logic [DigW-1:0] nd_q     [fsc_pkg::NumMod];
  logic [3:0]      chg_q;
  logic            left_q;

  // Configuration
  logic [CfgW-1:0] seg_write_q, between_q, digit_gap_q;

  // Held command and output register
  logic             pend_v_q;
  logic [ModW-1:0]  pend_mod_q;
  logic [SegW-1:0]  pend_seg_q;
  logic             pend_on_q, pend_flip_q;
  logic [WaitW-1:0] pend_wait_q;
  logic             out_v_q;
  logic [ModW-1:0]  out_mod_q;
  logic [SegW-1:0]  out_seg_q;
  logic             out_on_q, out_flip_q, out_last_q;
  logic [WaitW-1:0] out_wait_q;

  fsc_pkg::ctrl_t ctrl;

  // Step datapath
  logic [ModW-1:0]  cmd_mod, dig_mod;
  logic [SegW-1:0]  cmd_seg, cnt;
  logic [DigW-1:0]  digit, lead;
  logic             cmd_on, cmd_flip, emit, inner_end, done, active, last_stroke;
  logic [WaitW-1:0] cmd_wait;
  logic             out_busy, stall, advance, out_load, in_acc, cfg_wr;

  // Input decode
  fsc_pkg::act_e    act;
  logic [4:0]       hour_sat, hour_fold;
  logic [5:0]       min_sat;
  logic [DigW-1:0]  new_dig [fsc_pkg::NumMod];
  logic [3:0]       new_chg;

  // ---------------------------------------------------------------------------
  // Time split: saturate, fold to 12-hour form, split into digits
  always_comb begin
    act       = fsc_pkg::act_e'(s_tdata[1:0]);
    hour_sat  = (s_tdata[6:2] > fsc_pkg::HourMax) ? fsc_pkg::HourMax : s_tdata[6:2];
    min_sat   = (s_tdata[12:7] > fsc_pkg::MinuteMax) ? fsc_pkg::MinuteMax : s_tdata[12:7];
    hour_fold = (hour_sat > fsc_pkg::FoldAt) ? hour_sat - fsc_pkg::FoldAt : hour_sat;
    new_dig[0] = (hour_fold >= 5'd10) ? 4'd1 : 4'd0;
    new_dig[1] = DigW'(hour_fold - ((hour_fold >= 5'd10) ? 5'd10 : 5'd0));
    new_dig[2] = fsc_pkg::minute_tens(min_sat);
    new_dig[3] = DigW'(min_sat - {2'b00, new_dig[2]} * 6'd10);
    for (int m = 0; m < fsc_pkg::NumMod; m++) begin
      new_chg[m] = (act == fsc_pkg::ACT_INIT) || (new_dig[m] != shown_q[m]);
    end
  end

  // ---------------------------------------------------------------------------
  // Control word decode and one step of the datapath
  always_comb begin
    ctrl        = fsc_pkg::ucode(pc_q);
    cmd_mod     = mod_q;
    cmd_seg     = idx_q;
    cmd_on      = 1'b0;
    emit        = 1'b0;
    inner_end   = 1'b0;
    done        = 1'b0;
    cmd_wait    = WaitW'(seg_write_q);
    dig_mod     = (ctrl.op == fsc_pkg::OP_UNWRITE) ? ~mod_q : mod_q;
    digit       = (ctrl.op == fsc_pkg::OP_UNWRITE) ? shown_q[dig_mod] : nd_q[dig_mod];
    lead        = (ctrl.op == fsc_pkg::OP_UNWRITE) ? shown_q[0] : nd_q[0];
    cnt         = fsc_pkg::stroke_cnt(digit);
    active      = chg_q[dig_mod] && ((dig_mod != '0) || (lead != '0)) && (cnt != '0);
    last_stroke = (idx_q == cnt - 3'd1);
    unique case (ctrl.op)
      fsc_pkg::OP_CLEAR_ALL: begin
        emit      = 1'b1;
        inner_end = (idx_q == fsc_pkg::LastSeg);
        done      = inner_end && (mod_q == fsc_pkg::LastMod);
      end
      fsc_pkg::OP_WRITE, fsc_pkg::OP_UNWRITE: begin
        cmd_mod   = dig_mod;
        cmd_seg   = fsc_pkg::stroke(digit, idx_q);
        cmd_on    = (ctrl.op == fsc_pkg::OP_WRITE);
        emit      = active;
        cmd_wait  = WaitW'(seg_write_q) + WaitW'(between_q) +
                    (last_stroke ? WaitW'(digit_gap_q) : '0);
        inner_end = !active || last_stroke;
        done      = inner_end && (mod_q == fsc_pkg::LastMod);
      end
      fsc_pkg::OP_SWEEP: begin
        cmd_mod   = left_q ? ~mod_q : mod_q;
        cmd_seg   = fsc_pkg::pattern(left_q, idx_q);
        cmd_on    = pass_q;
        emit      = before_q[cmd_mod][cmd_seg];
        inner_end = (idx_q == fsc_pkg::LastSeg);
        done      = inner_end && (mod_q == fsc_pkg::LastMod) && pass_q;
      end
      default: begin
        done = 1'b1;
      end
    endcase
    cmd_flip = cmd_on ^ seg_q[cmd_mod][cmd_seg];
  end

  // ---------------------------------------------------------------------------
  // Handshake and stall
  assign out_busy = out_v_q && !m_tready;
  assign stall    = (((ctrl.op == fsc_pkg::OP_FLUSH) || emit) && pend_v_q && out_busy);
  assign advance  = !stall;
  assign s_tready = (ctrl.op == fsc_pkg::OP_WAIT);
  assign in_acc   = s_tvalid && s_tready;
  assign out_load = advance && pend_v_q && (emit || (ctrl.op == fsc_pkg::OP_FLUSH));
  assign cfg_wr   = psel && penable && pwrite;

  // Step counter and program counter
  always_comb begin
    pc_d   = pc_q;
    mod_d  = mod_q;
    idx_d  = idx_q;
    pass_d = pass_q;
    unique case (ctrl.op)
      fsc_pkg::OP_WAIT: begin
        if (in_acc) pc_d = fsc_pkg::dispatch(act);
        mod_d  = '0;
        idx_d  = '0;
        pass_d = 1'b0;
      end
      fsc_pkg::OP_COMMIT, fsc_pkg::OP_FLUSH: begin
        if (advance) pc_d = ctrl.next;
      end
      default: begin
        if (advance) begin
          if (done) begin
            pc_d   = ctrl.next;
            mod_d  = '0;
            idx_d  = '0;
            pass_d = 1'b0;
          end else if (inner_end) begin
            idx_d = '0;
            mod_d = mod_q + 2'd1;
            if (mod_q == fsc_pkg::LastMod) pass_d = ~pass_q;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control and clock state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= fsc_pkg::PcIdle;
      mod_q       <= '0;
      idx_q       <= '0;
      pass_q      <= 1'b0;
      pend_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
      seg_write_q <= fsc_pkg::SegWriteRst;
      between_q   <= fsc_pkg::BetweenRst;
      digit_gap_q <= fsc_pkg::DigitGapRst;
      for (int m = 0; m < fsc_pkg::NumMod; m++) begin
        seg_q[m]   <= '0;
        shown_q[m] <= '0;
      end
    end else begin
      pc_q   <= pc_d;
      mod_q  <= mod_d;
      idx_q  <= idx_d;
      pass_q <= pass_d;
      // segment state follows every emitted pulse
      if (advance && emit) begin
        seg_q[cmd_mod][cmd_seg] <= cmd_on;
        pend_v_q <= 1'b1;
      end else if (out_load) begin
        pend_v_q <= 1'b0;
      end
      if (out_load)      out_v_q <= 1'b1;
      else if (m_tready) out_v_q <= 1'b0;
      if (ctrl.op == fsc_pkg::OP_COMMIT) begin
        for (int m = 0; m < fsc_pkg::NumMod; m++) shown_q[m] <= nd_q[m];
      end
      // register writes
      if (cfg_wr) begin
        unique case (fsc_pkg::reg_idx_e'(paddr[3:2]))
          fsc_pkg::REG_SEG_WRITE: seg_write_q <= pwdata[CfgW-1:0];
          fsc_pkg::REG_BETWEEN:   between_q   <= pwdata[CfgW-1:0];
          fsc_pkg::REG_DIGIT_GAP: digit_gap_q <= pwdata[CfgW-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item context, held command and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      chg_q  <= new_chg;
      left_q <= (act == fsc_pkg::ACT_SWEEP_L);
      for (int m = 0; m < fsc_pkg::NumMod; m++) begin
        nd_q[m]     <= new_dig[m];
        before_q[m] <= seg_q[m];
      end
    end
    if (out_load) begin
      out_mod_q  <= pend_mod_q;
      out_seg_q  <= pend_seg_q;
      out_on_q   <= pend_on_q;
      out_flip_q <= pend_flip_q;
      out_wait_q <= pend_wait_q;
      out_last_q <= (ctrl.op == fsc_pkg::OP_FLUSH);
    end
    if (advance && emit) begin
      pend_mod_q  <= cmd_mod;
      pend_seg_q  <= cmd_seg;
      pend_on_q   <= cmd_on;
      pend_flip_q <= cmd_flip;
      pend_wait_q <= cmd_wait;
    end
  end

  // ---------------------------------------------------------------------------
  // Register read back
  always_comb begin
    prdata = '0;
    unique case (fsc_pkg::reg_idx_e'(paddr[3:2]))
      fsc_pkg::REG_SEG_WRITE: prdata = 32'(seg_write_q);
      fsc_pkg::REG_BETWEEN:   prdata = 32'(between_q);
      fsc_pkg::REG_DIGIT_GAP: prdata = 32'(digit_gap_q);
      default:                prdata = '0;
    endcase
  end

  assign pready   = 1'b1;
  assign m_tvalid = out_v_q;
  assign m_tdata  = {6'd0, out_wait_q, out_flip_q, out_seg_q, out_mod_q};
  assign m_tuser  = out_on_q;
  assign m_tlast  = out_last_q;

endmodule
